/* rtl/hypergeometric_at_least_probability_unit_assert.svh */
// Assertion macros for the hypergeometric tail probability unit.
// Included by modules that check their own control sequencing.
`ifndef HYPERGEOMETRIC_AT_LEAST_PROBABILITY_UNIT_ASSERT_SVH
`define HYPERGEOMETRIC_AT_LEAST_PROBABILITY_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define HALP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
`define HALP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define HALP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HALP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/halp_pkg.sv */
// Shared types and constants of the hypergeometric tail probability unit.
// No dependencies.
package halp_pkg;

  localparam int IN_W       = 32;
  localparam int PROB_W     = 32;
  localparam int CNT_W      = 4;
  localparam int POOL_W     = 7;
  localparam int ACC_W      = 64;
  localparam int MD_M_W     = 7;
  localparam int MD_D_W     = 4;
  localparam int DIGIT_W    = 8;
  localparam int MD_NDIG    = 9;
  localparam int MD_P_W     = DIGIT_W * MD_NDIG;
  localparam int MD_CNT_W   = $clog2(MD_NDIG + 1);

  typedef enum logic [1:0] {
    CLS_INVALID,
    CLS_ONE,
    CLS_ZERO,
    CLS_COMPUTE
  } cls_t;

  typedef enum logic [1:0] {
    SEL_TOTAL,
    SEL_A,
    SEL_B
  } bn_sel_t;

  typedef struct packed {
    logic    load;
    logic    bn_init;
    bn_sel_t bn_sel;
    logic    md_start;
    logic    bn_step;
    logic    bn_store;
    logic    term_init;
    logic    term_next;
    logic    div_init;
    logic    div_step;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    cls_t    cls;
    bn_sel_t bn_sel;
    logic    bn_done;
    logic    md_done;
    logic    term_done;
    logic    div_done;
  } status_t;

endpackage

/* rtl/halp_muldiv.sv */
// Iterative exact multiply-divide: floor(x * m / d), low 64 bits kept.
// The product is registered first, then one quotient byte per cycle. Uses halp_pkg.
module halp_muldiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [halp_pkg::ACC_W-1:0]   x,
  input  logic [halp_pkg::MD_M_W-1:0]  m,
  input  logic [halp_pkg::MD_D_W-1:0]  d,
  output logic                         done,
  output logic [halp_pkg::ACC_W-1:0]   q
);
  import halp_pkg::*;

  logic [MD_P_W-1:0]   prod_r;
  logic [ACC_W-1:0]    quo_r;
  logic [MD_D_W-1:0]   rem_r;
  logic [MD_D_W-1:0]   d_r;
  logic [MD_CNT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [MD_D_W-1:0]   rem_nxt;
  logic [DIGIT_W-1:0]  dig;
  logic [MD_D_W:0]     trial;
  logic [MD_P_W-1:0]   prod_nxt;

  assign prod_nxt = MD_P_W'(x) * MD_P_W'(m);

  always_comb begin
    rem_nxt = rem_r;
    dig     = '0;
    trial   = '0;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      trial = {rem_nxt, prod_r[MD_P_W-DIGIT_W+b]};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = MD_D_W'(trial - {1'b0, d_r});
        dig[b]  = 1'b1;
      end else begin
        rem_nxt = trial[MD_D_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MD_CNT_W'(MD_NDIG);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == MD_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
      rem_r  <= '0;
      d_r    <= d;
    end else if (busy_r) begin
      prod_r <= prod_r << DIGIT_W;
      quo_r  <= {quo_r[ACC_W-DIGIT_W-1:0], dig};
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign q    = quo_r;

endmodule

/* rtl/halp_dp.sv */
// Datapath: input capture and classification, binomial sequencing through
// the multiply-divide unit, tail sum and restoring fraction division.
// Uses halp_pkg and halp_muldiv.
module halp_dp #(
  parameter int REFILL_SIZE   = 7,
  parameter int POOL_CAPACITY = 127,
  parameter int FRACTION_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [halp_pkg::IN_W-1:0]    in_data,
  input  halp_pkg::cmd_t               cmd,
  output halp_pkg::status_t            status,
  output logic [halp_pkg::PROB_W-1:0]  prob,
  output logic                         invalid
);
  import halp_pkg::*;

  localparam int CW = $clog2(FRACTION_BITS + 1);
  localparam logic [63:0] ONE_FULL = 64'd1 << FRACTION_BITS;
  localparam logic [PROB_W-1:0] ONE_P = ONE_FULL[PROB_W-1:0];

  logic [POOL_W-1:0]        f_pool, f_spool;
  logic [CNT_W-1:0]         f_hand, f_shand, f_minc, f_played;
  logic signed [5:0]        need_s;
  logic signed [6:0]        draw_s;
  cls_t                     cls_c;

  cls_t                     cls_r;
  logic [POOL_W-1:0]        pool_r, spool_r;
  logic [CNT_W-1:0]         need_r, draw_r;
  logic [CNT_W:0]           i_r;
  logic [POOL_W-1:0]        bn_n_r;
  logic [CNT_W-1:0]         bn_k_r;
  logic [CNT_W:0]           bn_j_r;
  bn_sel_t                  bn_sel_r;
  logic [ACC_W-1:0]         acc_r, total_r, num_r, rem_r;
  logic [FRACTION_BITS-1:0] q_r;
  logic [CW-1:0]            div_cnt_r;
  logic [PROB_W-1:0]        prob_r;
  logic                     inv_r;

  logic [POOL_W-1:0]        n_c;
  logic [CNT_W-1:0]         k_c;
  logic [POOL_W:0]          m_c;
  logic [ACC_W-1:0]         md_q;
  logic                     md_done;
  logic [ACC_W-1:0]         shl_c;

  assign f_pool   = in_data[6:0];
  assign f_spool  = in_data[13:7];
  assign f_hand   = in_data[17:14];
  assign f_shand  = in_data[21:18];
  assign f_minc   = in_data[25:22];
  assign f_played = in_data[29:26];

  always_comb begin
    need_s = $signed({2'b0, f_minc}) - $signed({2'b0, f_shand});
    draw_s = $signed(7'(REFILL_SIZE)) - $signed({3'b0, f_hand}) - $signed({3'b0, f_played});
    if (f_spool > f_pool || {1'b0, f_pool} > 8'(POOL_CAPACITY)) begin
      cls_c = CLS_INVALID;
    end else if (need_s <= 6'sd0) begin
      cls_c = CLS_ONE;
    end else if (f_spool < {2'b0, need_s[4:0]}) begin
      cls_c = CLS_ZERO;
    end else if (draw_s <= 7'sd0) begin
      cls_c = CLS_ZERO;
    end else if (f_pool <= {2'b0, draw_s[4:0]}) begin
      cls_c = CLS_ONE;
    end else begin
      cls_c = CLS_COMPUTE;
    end
  end

  always_comb begin
    case (cmd.bn_sel)
      SEL_TOTAL: begin
        n_c = pool_r;
        k_c = draw_r;
      end
      SEL_A: begin
        n_c = spool_r;
        k_c = i_r[CNT_W-1:0];
      end
      default: begin
        n_c = pool_r - spool_r;
        k_c = draw_r - i_r[CNT_W-1:0];
      end
    endcase
  end

  assign m_c   = {1'b0, bn_n_r} - {4'b0, bn_k_r} + {3'b0, bn_j_r};
  assign shl_c = {rem_r[ACC_W-2:0], 1'b0};

  halp_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.md_start),
    .x     (acc_r),
    .m     (m_c[MD_M_W-1:0]),
    .d     (bn_j_r[MD_D_W-1:0]),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cls_r   <= cls_c;
      pool_r  <= f_pool;
      spool_r <= f_spool;
      need_r  <= need_s[CNT_W-1:0];
      draw_r  <= draw_s[CNT_W-1:0];
    end
    if (cmd.term_init) begin
      i_r   <= {1'b0, need_r};
      num_r <= '0;
    end else if (cmd.term_next) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.bn_store) begin
      if (bn_sel_r == SEL_TOTAL) begin
        total_r <= acc_r;
      end
      if (bn_sel_r == SEL_B) begin
        num_r <= num_r + acc_r;
      end
    end
    if (cmd.bn_init) begin
      bn_n_r   <= n_c;
      bn_k_r   <= k_c;
      bn_j_r   <= (CNT_W + 1)'(1);
      bn_sel_r <= cmd.bn_sel;
      if ({3'b0, k_c} > n_c) begin
        acc_r <= '0;
      end else if (cmd.bn_sel != SEL_B) begin
        acc_r <= ACC_W'(1);
      end
    end else if (cmd.bn_step) begin
      acc_r  <= md_q;
      bn_j_r <= bn_j_r + 1'b1;
    end
    if (cmd.div_init) begin
      rem_r     <= num_r;
      q_r       <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (rem_r[ACC_W-1] || shl_c >= total_r) begin
        rem_r <= shl_c - total_r;
        q_r   <= {q_r[FRACTION_BITS-2:0], 1'b1};
      end else begin
        rem_r <= shl_c;
        q_r   <= {q_r[FRACTION_BITS-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      inv_r <= (cls_r == CLS_INVALID);
      case (cls_r)
        CLS_INVALID: prob_r <= '0;
        CLS_ONE:     prob_r <= ONE_P;
        CLS_ZERO:    prob_r <= '0;
        default: begin
          if (total_r == '0) begin
            prob_r <= '0;
          end else if (num_r >= total_r) begin
            prob_r <= ONE_P;
          end else begin
            prob_r <= PROB_W'(q_r);
          end
        end
      endcase
    end
  end

  always_comb begin
    status.cls       = cls_r;
    status.bn_sel    = bn_sel_r;
    status.bn_done   = (bn_j_r > {1'b0, bn_k_r}) || (acc_r == '0);
    status.md_done   = md_done;
    status.term_done = i_r > {1'b0, draw_r};
    status.div_done  = div_cnt_r == CW'(FRACTION_BITS);
  end

  assign prob    = prob_r;
  assign invalid = inv_r;

endmodule

/* rtl/halp_ctrl.sv */
// Controller: sequences load, binomial evaluation, tail sum, division and
// result hand-off. Uses halp_pkg and the assertion macro header.
`include "hypergeometric_at_least_probability_unit_assert.svh"
module halp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  halp_pkg::status_t   status,
  output halp_pkg::cmd_t      cmd
);
  import halp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BN_RUN,
    ST_MD_WAIT,
    ST_TERM_CHK,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.cls != CLS_COMPUTE) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.bn_init = 1'b1;
          cmd.bn_sel  = SEL_TOTAL;
          state_nxt   = ST_BN_RUN;
        end
      end
      ST_BN_RUN: begin
        if (status.bn_done) begin
          cmd.bn_store = 1'b1;
          case (status.bn_sel)
            SEL_TOTAL: begin
              cmd.term_init = 1'b1;
              state_nxt     = ST_TERM_CHK;
            end
            SEL_A: begin
              cmd.bn_init = 1'b1;
              cmd.bn_sel  = SEL_B;
            end
            default: begin
              cmd.term_next = 1'b1;
              state_nxt     = ST_TERM_CHK;
            end
          endcase
        end else begin
          cmd.md_start = 1'b1;
          state_nxt    = ST_MD_WAIT;
        end
      end
      ST_MD_WAIT: begin
        if (status.md_done) begin
          cmd.bn_step = 1'b1;
          state_nxt   = ST_BN_RUN;
        end
      end
      ST_TERM_CHK: begin
        if (status.term_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          cmd.bn_init = 1'b1;
          cmd.bn_sel  = SEL_A;
          state_nxt   = ST_BN_RUN;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.finish     = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;

  `HALP_ASSERT_IMP(a_md_done_in_wait, clk, rst_n, status.md_done, state_r == ST_MD_WAIT)
  `HALP_ASSERT_IMP(a_out_from_fin, clk, rst_n, $rose(out_tvalid_r), $past(state_r) == ST_FIN)
  `HALP_ASSERT_NXT(a_div_not_instant, clk, rst_n, cmd.div_init, !status.div_done)

endmodule

/* rtl/hypergeometric_at_least_probability_unit.sv */
// Invalid, certain or impossible cases go from the check straight to the result.
// Otherwise T = draw - need + 1 terms are summed, in up to S = draw * (T + 1)
// binomial steps, each run on the byte-serial multiply-divide unit.
// One item at a time; the next is taken while a finished result waits for out_tready.
// Reset: synchronous, active low; clears the controller and the output valid.
// Top level: joins halp_ctrl and halp_dp; uses halp_pkg.
module hypergeometric_at_least_probability_unit #(
  parameter int REFILL_SIZE   = 7,
  parameter int POOL_CAPACITY = 127,
  parameter int FRACTION_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pool_total, symbol_in_pool, hand_total, symbol_in_hand, min_count,
  // played_count, zero fill
  input  logic [halp_pkg::IN_W-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // probability
  output logic [halp_pkg::PROB_W-1:0]   out_tdata,
  // invalid
  output logic                          out_tuser
);
  import halp_pkg::*;

  cmd_t    cmd;
  status_t status;

  halp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  halp_dp #(
    .REFILL_SIZE   (REFILL_SIZE),
    .POOL_CAPACITY (POOL_CAPACITY),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_tdata),
    .cmd     (cmd),
    .status  (status),
    .prob    (out_tdata),
    .invalid (out_tuser)
  );

endmodule

/* sim/tb_hypergeometric_at_least_probability_unit.sv */
// Testbench of hypergeometric_at_least_probability_unit: directed, random refill and
// random noise queries, each result checked against a built-in tail probability predictor.
// Depends on halp_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_hypergeometric_at_least_probability_unit;
  import halp_pkg::*;

  localparam int REFILL_SIZE   = 7;
  localparam int POOL_CAPACITY = 127;
  localparam int FRACTION_BITS = 31;
  localparam logic [63:0] UNIT = 64'd1 << FRACTION_BITS;
  localparam int DRAIN_CYCLES  = 800;

  typedef struct {
    bit [POOL_W-1:0] pool_total;
    bit [POOL_W-1:0] symbol_in_pool;
    bit [CNT_W-1:0]  hand_total;
    bit [CNT_W-1:0]  symbol_in_hand;
    bit [CNT_W-1:0]  min_count;
    bit [CNT_W-1:0]  played_count;
  } query_t;

  typedef struct {
    logic [PROB_W-1:0] probability;
    logic              invalid;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [PROB_W-1:0] out_tdata;
  logic              out_tuser;

  verdict_t expected_tails[$];
  verdict_t oldest_tail;
  int       mismatches = 0;
  int       hold_off_left = 0;
  int       stall_left = 0;
  bit       steady = 0;

  hypergeometric_at_least_probability_unit #(
    .REFILL_SIZE  (REFILL_SIZE),
    .POOL_CAPACITY(POOL_CAPACITY),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] choose(int n, int k);
    logic [63:0] acc;
    acc = 64'd1;
    if (n < k) begin
      return 64'd0;
    end
    for (int j = 1; j <= k; j++) begin
      acc = acc * 64'(n - k + j) / 64'(j);
    end
    return acc;
  endfunction

  function automatic verdict_t predict_tail(query_t q);
    verdict_t     v;
    int           need;
    int           draw;
    int           pool;
    int           spool;
    logic [63:0]  total;
    logic [63:0]  num;
    logic [127:0] quotient;
    v.probability = '0;
    v.invalid     = 1'b0;
    pool  = int'(q.pool_total);
    spool = int'(q.symbol_in_pool);
    if (spool > pool || pool > POOL_CAPACITY) begin
      v.invalid = 1'b1;
    end else begin
      need = int'(q.min_count) - int'(q.symbol_in_hand);
      draw = REFILL_SIZE - (int'(q.hand_total) + int'(q.played_count));
      if (need <= 0) begin
        v.probability = UNIT[PROB_W-1:0];
      end else if (spool < need || draw <= 0) begin
        v.probability = '0;
      end else if (pool <= draw) begin
        v.probability = UNIT[PROB_W-1:0];
      end else begin
        total = choose(pool, draw);
        num   = 64'd0;
        for (int i = need; i <= draw; i++) begin
          num += choose(spool, i) * choose(pool - spool, draw - i);
        end
        if (num >= total) begin
          v.probability = UNIT[PROB_W-1:0];
        end else begin
          quotient      = ({64'd0, num} << FRACTION_BITS) / {64'd0, total};
          v.probability = quotient[PROB_W-1:0];
        end
      end
    end
    return v;
  endfunction

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 9) < 6) begin
      return 0;
    end
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic query_t make_query(int pool, int spool, int hand, int shand, int minc,
                                        int played);
    query_t q;
    q.pool_total     = POOL_W'(pool);
    q.symbol_in_pool = POOL_W'(spool);
    q.hand_total     = CNT_W'(hand);
    q.symbol_in_hand = CNT_W'(shand);
    q.min_count      = CNT_W'(minc);
    q.played_count   = CNT_W'(played);
    return q;
  endfunction

  function automatic query_t random_refill();
    int hand;
    int played;
    int draw;
    int pool;
    int shand;
    int need;
    hand   = $urandom_range(0, REFILL_SIZE - 1);
    played = $urandom_range(0, REFILL_SIZE - 1 - hand);
    draw   = REFILL_SIZE - hand - played;
    pool   = $urandom_range(draw + 1, ($urandom_range(0, 3) == 0) ? POOL_CAPACITY : 40);
    shand  = $urandom_range(0, 15 - draw);
    need   = $urandom_range(1, draw);
    return make_query(pool, $urandom_range(need, pool), hand, shand, shand + need, played);
  endfunction

  function automatic query_t random_noise();
    query_t q;
    q.pool_total     = POOL_W'($urandom);
    q.symbol_in_pool = POOL_W'($urandom);
    q.hand_total     = CNT_W'($urandom);
    q.symbol_in_hand = CNT_W'($urandom);
    q.min_count      = CNT_W'($urandom);
    q.played_count   = CNT_W'($urandom);
    return q;
  endfunction

  task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
    $display("ERROR at %0t: %s expected 0x%0h, got 0x%0h", $realtime, field, want, got);
    mismatches++;
  endtask

  task automatic send_query(query_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, q.played_count, q.min_count, q.symbol_in_hand, q.hand_total,
                  q.symbol_in_pool, q.pool_total};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_tails.push_back(predict_tail(q));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tails.size() == 0) begin
        report_mismatch("unexpected result, probability", 64'd0, 64'(out_tdata));
      end else begin
        oldest_tail = expected_tails.pop_front();
        if (out_tdata !== oldest_tail.probability) begin
          report_mismatch("probability", 64'(oldest_tail.probability), 64'(out_tdata));
        end
        if (out_tuser !== oldest_tail.invalid) begin
          report_mismatch("invalid", 64'(oldest_tail.invalid), 64'(out_tuser));
        end
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_tready <= 1'b0;
        hold_off_left--;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end
    end
  end

  task automatic test_special_cases();
    send_query(make_query(0, 0, 0, 0, 0, 0));
    send_query(make_query(5, 6, 0, 0, 1, 0));
    send_query(make_query(0, 127, 0, 0, 1, 0));
    send_query(make_query(127, 127, 0, 0, 7, 0));
    send_query(make_query(127, 126, 15, 15, 15, 15));
    send_query(make_query(100, 1, 0, 0, 3, 0));
    send_query(make_query(50, 5, 7, 0, 1, 0));
    send_query(make_query(50, 10, 15, 0, 1, 15));
    send_query(make_query(3, 2, 2, 0, 2, 0));
    send_query(make_query(7, 1, 0, 0, 1, 0));
    send_query(make_query(127, 1, 0, 0, 1, 0));
    send_query(make_query(100, 9, 0, 0, 7, 0));
    send_query(make_query(8, 7, 0, 0, 1, 0));
    send_query(make_query(60, 20, 4, 3, 5, 1));
    send_query(make_query(127, 90, 0, 8, 15, 0));
    send_query(make_query(2, 1, 3, 0, 1, 3));
    send_query(make_query(127, 127, 0, 0, 15, 0));
    send_query(make_query(127, 0, 0, 0, 1, 0));
    send_query(make_query(126, 127, 0, 0, 0, 0));
    send_query(make_query(1, 1, 6, 0, 1, 0));
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (60) send_query(($urandom_range(0, 3) == 0) ? random_noise() : random_refill());
    steady = 1'b0;
  endtask

  task automatic test_output_hold_off();
    hold_off_left = 600;
    repeat (8) send_query(random_refill());
  endtask

  task automatic test_random_mix();
    repeat (1570) send_query(($urandom_range(0, 9) < 7) ? random_refill() : random_noise());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_special_cases();
    test_back_to_back();
    test_output_hold_off();
    test_random_mix();
    in_tvalid <= 1'b0;
    wait (expected_tails.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
